### rtl/taylor_sin_cos_tan_macros.svh
// Assertion macros for the sine, cosine and tangent block.
// Used by the checker; depends on a clk and rst in scope.
`ifndef TAYLOR_SIN_COS_TAN_MACROS_SVH
`define TAYLOR_SIN_COS_TAN_MACROS_SVH

// check a property outside reset
`define TSCT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tsct assertion failed");

// check a property at every edge, reset included
`define TSCT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tsct assertion failed");

`endif

### rtl/tsct_pkg.sv
// Shared constants and stage types for the sine, cosine and tangent block.
// No dependencies.
`default_nettype none
package tsct_pkg;

  localparam int MAX_ORDER = 24;
  localparam int NSTEP     = MAX_ORDER / 2;
  localparam int NUM_W     = 47;

  localparam logic [31:0]        ANGLE_LIMIT = 32'd1686629713;
  localparam logic [31:0]        ONE_TERM    = 32'd1073741824;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic [31:0]        TAN_POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0]        TAN_NEG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic               valid;
    logic               xneg;
    logic [31:0]        x2;
    logic [31:0]        tc;
    logic [31:0]        ts;
    logic signed [33:0] acc_c;
    logic signed [33:0] acc_s;
  } ser_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic             sneg;
    logic             cneg;
    logic [31:0]      sine;
    logic [31:0]      cosine;
    logic [30:0]      dvs;
    logic [NUM_W-1:0] num;
    logic [29:0]      rem;
    logic [NUM_W-1:0] quo;
  } div_t;

endpackage
`default_nettype wire

### rtl/tsct_series_cell.sv
// One series step: adds the current sine and cosine terms, forms the next ones.
// Depends on tsct_pkg.
`default_nettype none
module tsct_series_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic [31:0]   r_c,
  input  wire logic [31:0]   r_s,
  input  wire logic          neg,
  input  wire tsct_pkg::ser_t data_i,
  output tsct_pkg::ser_t     data_o
);

  tsct_pkg::ser_t a;
  tsct_pkg::ser_t a_next;
  tsct_pkg::ser_t b_next;
  logic [63:0] prod_c;
  logic [63:0] prod_s;
  logic [63:0] prod_rc;
  logic [63:0] prod_rs;

  always_comb begin
    a_next = data_i;
    prod_c = data_i.tc * data_i.x2;
    prod_s = data_i.ts * data_i.x2;
    a_next.tc = 32'((prod_c + 64'd536870912) >> 30);
    a_next.ts = 32'((prod_s + 64'd536870912) >> 30);
    if (neg) begin
      a_next.acc_c = data_i.acc_c - $signed({2'b00, data_i.tc});
      a_next.acc_s = data_i.acc_s - $signed({2'b00, data_i.ts});
    end else begin
      a_next.acc_c = data_i.acc_c + $signed({2'b00, data_i.tc});
      a_next.acc_s = data_i.acc_s + $signed({2'b00, data_i.ts});
    end
  end

  always_comb begin
    b_next  = a;
    prod_rc = a.tc * r_c;
    prod_rs = a.ts * r_s;
    b_next.tc = 32'((prod_rc + 64'd2147483648) >> 32);
    b_next.ts = 32'((prod_rs + 64'd2147483648) >> 32);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a.valid      <= 1'b0;
      data_o.valid <= 1'b0;
    end else if (en) begin
      a      <= a_next;
      data_o <= b_next;
    end
  end

endmodule
`default_nettype wire

### rtl/tsct_div_cell.sv
// One restoring division step: one quotient bit of the tangent per cell.
// Depends on tsct_pkg.
`default_nettype none
module tsct_div_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire tsct_pkg::div_t data_i,
  output tsct_pkg::div_t     data_o
);

  tsct_pkg::div_t d_next;
  logic [30:0] rem_sh;
  logic        ge;

  always_comb begin
    d_next = data_i;
    rem_sh = {data_i.rem, data_i.num[tsct_pkg::NUM_W-1]};
    ge     = rem_sh >= data_i.dvs;
    d_next.rem = ge ? 30'(rem_sh - data_i.dvs) : rem_sh[29:0];
    d_next.num = {data_i.num[tsct_pkg::NUM_W-2:0], 1'b0};
    d_next.quo = {data_i.quo[tsct_pkg::NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_o.valid <= 1'b0;
    end else if (en) begin
      data_o <= d_next;
    end
  end

endmodule
`default_nettype wire

### rtl/taylor_sin_cos_tan.sv
// Top level: angle clamp and square, a row of series cells, saturation,
// and a row of division cells for the tangent. Depends on tsct_pkg and cells.
//
//  channel | dir | tdata                                   | tuser
//  s_      | in  | angle [31:0]                            | -
//  m_      | out | sine [31:0] cosine [63:32] tan [95:64]  | tan_saturated
//
// One angle enters per cycle while the output is not stalled; the pipeline has
// two stages for each pair of series terms and one per quotient bit.
// Reset is synchronous and clears every stage valid and the output valid.
// An output stall holds the whole pipeline; s_tready follows it.
`default_nettype none
module taylor_sin_cos_tan (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // angle
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // sine, cosine, tangent
  output logic             m_tuser    // tan_saturated
);

  localparam int NS = tsct_pkg::NSTEP;
  localparam int NW = tsct_pkg::NUM_W;

  logic        advance;
  logic        v0;
  logic        xneg0;
  logic [30:0] ax0;
  logic [31:0] mag;
  logic [61:0] sq;

  tsct_pkg::ser_t ser [NS+1];
  tsct_pkg::div_t dv  [NW+1];

  logic               vf;
  logic signed [31:0] sf;
  logic signed [31:0] cf;
  logic signed [33:0] acc_c_end;
  logic signed [33:0] acc_s_end;
  logic signed [33:0] s_sat;
  logic signed [33:0] c_sat;
  logic [31:0]        as_w;
  logic [31:0]        ac_w;
  logic [NW-1:0]      q;
  logic               qneg;
  logic [31:0]        tan_w;
  logic               flag_w;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign mag      = s_tdata[31] ? 32'(-s_tdata) : s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (advance) begin
      v0    <= s_tvalid;
      xneg0 <= s_tdata[31];
      ax0   <= (mag > tsct_pkg::ANGLE_LIMIT) ? tsct_pkg::ANGLE_LIMIT[30:0] : mag[30:0];
    end
  end

  assign sq = ax0 * ax0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser[0].valid <= 1'b0;
    end else if (advance) begin
      ser[0].valid <= v0;
      ser[0].xneg  <= xneg0;
      ser[0].x2    <= 32'((sq + 62'd536870912) >> 30);
      ser[0].tc    <= tsct_pkg::ONE_TERM;
      ser[0].ts    <= {1'b0, ax0};
      ser[0].acc_c <= '0;
      ser[0].acc_s <= '0;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_ser
    localparam logic [63:0] DC = 64'((2 * j + 1) * (2 * j + 2));
    localparam logic [63:0] DS = 64'((2 * j + 2) * (2 * j + 3));
    localparam logic [63:0] RC = ((64'd1 << 32) + DC / 2) / DC;
    localparam logic [63:0] RS = ((64'd1 << 32) + DS / 2) / DS;
    tsct_series_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (advance),
      .r_c    (RC[31:0]),
      .r_s    (RS[31:0]),
      .neg    (1'(j % 2)),
      .data_i (ser[j]),
      .data_o (ser[j+1])
    );
  end

  always_comb begin
    if ((NS % 2) == 1) begin
      acc_c_end = ser[NS].acc_c - $signed({2'b00, ser[NS].tc});
      acc_s_end = ser[NS].acc_s - $signed({2'b00, ser[NS].ts});
    end else begin
      acc_c_end = ser[NS].acc_c + $signed({2'b00, ser[NS].tc});
      acc_s_end = ser[NS].acc_s + $signed({2'b00, ser[NS].ts});
    end
    if ((tsct_pkg::MAX_ORDER % 2) == 0) begin
      acc_s_end = ser[NS].acc_s;
    end
    if (acc_s_end > tsct_pkg::ONE_Q30) begin
      s_sat = tsct_pkg::ONE_Q30;
    end else if (acc_s_end < -tsct_pkg::ONE_Q30) begin
      s_sat = -tsct_pkg::ONE_Q30;
    end else begin
      s_sat = acc_s_end;
    end
    if (acc_c_end > tsct_pkg::ONE_Q30) begin
      c_sat = tsct_pkg::ONE_Q30;
    end else if (acc_c_end < -tsct_pkg::ONE_Q30) begin
      c_sat = -tsct_pkg::ONE_Q30;
    end else begin
      c_sat = acc_c_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (advance) begin
      vf    <= ser[NS].valid;
      sf    <= ser[NS].xneg ? 32'(-s_sat) : s_sat[31:0];
      cf    <= c_sat[31:0];
    end
  end

  assign as_w = sf[31] ? 32'(-sf) : sf;
  assign ac_w = cf[31] ? 32'(-cf) : cf;

  always_comb begin
    dv[0].valid  = vf;
    dv[0].zero   = (ac_w == 32'd0);
    dv[0].sneg   = sf[31];
    dv[0].cneg   = cf[31];
    dv[0].sine   = sf;
    dv[0].cosine = cf;
    dv[0].dvs    = ac_w[30:0];
    dv[0].num    = NW'({as_w, 16'd0}) + NW'(ac_w[30:1]);
    dv[0].rem    = '0;
    dv[0].quo    = '0;
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    tsct_div_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (advance),
      .data_i (dv[k]),
      .data_o (dv[k+1])
    );
  end

  always_comb begin
    q      = dv[NW].quo;
    qneg   = (dv[NW].sneg != dv[NW].cneg) && (q != '0);
    flag_w = 1'b0;
    if (dv[NW].zero) begin
      flag_w = 1'b1;
      tan_w  = dv[NW].sneg ? tsct_pkg::TAN_NEG_MAX : tsct_pkg::TAN_POS_MAX;
    end else if (qneg) begin
      if (q > NW'(64'd2147483648)) begin
        flag_w = 1'b1;
        tan_w  = tsct_pkg::TAN_NEG_MAX;
      end else begin
        tan_w  = 32'(-q);
      end
    end else begin
      if (q > NW'(64'd2147483647)) begin
        flag_w = 1'b1;
        tan_w  = tsct_pkg::TAN_POS_MAX;
      end else begin
        tan_w  = q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= dv[NW].valid;
      m_tdata  <= {tan_w, dv[NW].cosine, dv[NW].sine};
      m_tuser  <= flag_w;
    end
  end

endmodule
`default_nettype wire

### rtl/taylor_sin_cos_tan_checker.sv
// Port-level checks for the sine, cosine and tangent block, bound to the top.
// Depends on taylor_sin_cos_tan_macros.svh.
`default_nettype none
`include "taylor_sin_cos_tan_macros.svh"
module taylor_sin_cos_tan_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata,
  input wire logic        m_tuser
);

  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  logic signed [31:0] sine_v;
  logic [31:0]        tan_v;

  assign sine_v = m_tdata[31:0];
  assign tan_v  = m_tdata[95:64];

  `TSCT_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `TSCT_ASSERT_ALWAYS(a_reset, rst |=> !m_tvalid)
  `TSCT_ASSERT(a_sine_range, m_tvalid |-> (sine_v <= ONE_Q30) && (sine_v >= -ONE_Q30))
  `TSCT_ASSERT(a_sat_tan, m_tvalid && m_tuser |-> tan_v == 32'h7fff_ffff || tan_v == 32'h8000_0000)
  `TSCT_ASSERT(a_stall, s_tvalid && !s_tready |-> m_tvalid && !m_tready)

endmodule

bind taylor_sin_cos_tan taylor_sin_cos_tan_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
